>>> hw/rtl/pru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_MAX_SCALE = 16;

	// register file
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int SCALE_W    = 5;
	localparam int ROW_W      = 12;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = CFG_IDX_W'(1);

	// stream payload
	localparam int PIX_W      = 24;
	localparam int PADB_W     = 2;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 32;
	localparam int M_USER_W   = 3;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TICK  = 1'b1;

endpackage : pru_pkg

`default_nettype wire

>>> hw/rtl/pru_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pru_ram #(
	parameter int W = 24,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : pru_ram

`default_nettype wire

>>> hw/rtl/pixel_replicate_upscaler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// The first result of a request passes the s1 register, the s2 generator and the output register to m_*.
// Throughput: one result per cycle while m_tready does not stall it; a request yields scale copies,
// one more result when it closes a row that needs padding, and a rejected request yields one result.
// Requests flow back to back through the line buffer stage and the result generator.
// Reset (arst_n low, async): clears counters, pipeline valids and config (scale=1,
// row_width=1). The line buffer is not cleared; no clearing pass is run.

module pixel_replicate_upscaler_core #(
	parameter int MAX_WIDTH = pru_pkg::DEF_MAX_WIDTH,
	parameter int MAX_SCALE = pru_pkg::DEF_MAX_SCALE
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [pru_pkg::S_DATA_W-1:0]  s_tdata,  // [23:0] pixel_in
	input  wire logic                          s_tuser,  // [0] operation
	// output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [pru_pkg::M_DATA_W-1:0]       m_tdata,  // [23:0] pixel_out, [25:24] pad_bytes
	output logic [pru_pkg::M_USER_W-1:0]       m_tuser,  // [0] is_padding, [1] row_end, [2] rejected
	output logic                               m_tlast   // last result of the request
);

	import pru_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column index
	localparam int WW = $clog2(MAX_WIDTH + 1);                     // width / column+1
	localparam int CW = $clog2(MAX_SCALE + 1);                     // scale / copy count

	// ---------------------------------------------------------------------
	// Config registers
	// ---------------------------------------------------------------------
	logic [SCALE_W-1:0] scale_q;
	logic [ROW_W-1:0]   row_width_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_W'(1);
			row_width_q <= ROW_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				REG_ROW_WIDTH: row_width_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp to the supported range
	logic [CW-1:0] s_eff;
	logic [WW-1:0] w_eff;
	logic [1:0]    pad_prod;
	logic [1:0]    pad_cnt;

	always_comb begin
		if (scale_q == '0) begin
			s_eff = CW'(1);
		end else if (32'(scale_q) > MAX_SCALE) begin
			s_eff = CW'(MAX_SCALE);
		end else begin
			s_eff = CW'(scale_q);
		end
		if (row_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(row_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(row_width_q);
		end
	end

	// (w*s) mod 4 only needs the low two bits of each
	assign pad_prod = 2'(w_eff) * 2'(s_eff);
	assign pad_cnt  = pad_prod[1:0];

	// ---------------------------------------------------------------------
	// Stage 0: accept, update column state, touch the line buffer
	// ---------------------------------------------------------------------
	logic [AW-1:0] fill_q;
	logic [AW-1:0] replay_col_q;
	logic [CW-1:0] replays_q;

	logic          in_fire;
	logic          job_free;
	logic          v_s1;
	logic          rej_s1;
	logic          use_ram_s1;
	logic          done_s1;
	logic [PIX_W-1:0] pix_s1;

	logic [WW-1:0] fill_next;
	logic [WW-1:0] replay_next;
	logic          fill_done;
	logic          replay_done;
	logic          pend;
	logic          is_tick;
	logic          ram_we;
	logic          ram_re;
	logic [PIX_W-1:0] ram_rdata;

	assign s_tready    = !v_s1 || job_free;
	assign in_fire     = s_tvalid && s_tready;
	assign pend        = (replays_q != '0);
	assign is_tick     = (s_tuser == OP_TICK);
	assign fill_next   = WW'(fill_q) + WW'(1);
	assign replay_next = WW'(replay_col_q) + WW'(1);
	assign fill_done   = (fill_next >= w_eff);
	assign replay_done = (replay_next >= w_eff);
	assign ram_we      = in_fire && !is_tick && !pend;
	assign ram_re      = in_fire && is_tick && pend;

	pru_ram #(
		.W     (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (s_tdata[PIX_W-1:0]),
		.re    (ram_re),
		.raddr (replay_col_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			replay_col_q <= '0;
			replays_q    <= '0;
		end else if (ram_we) begin
			if (fill_done) begin
				fill_q       <= '0;
				replays_q    <= s_eff - CW'(1);
				replay_col_q <= '0;
			end else begin
				fill_q <= AW'(fill_next);
			end
		end else if (ram_re) begin
			if (replay_done) begin
				replay_col_q <= '0;
				replays_q    <= replays_q - CW'(1);
			end else begin
				replay_col_q <= AW'(replay_next);
			end
		end
	end

	// s1: request waiting for the generator; tick with nothing pending drops out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= in_fire && (!is_tick || pend);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rej_s1     <= !is_tick && pend;
			use_ram_s1 <= is_tick;
			done_s1    <= is_tick ? replay_done : fill_done;
			pix_s1     <= s_tdata[PIX_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// s2: result generator, one result per cycle while m_tready does not stall it, into the output register
	// ---------------------------------------------------------------------
	logic             v_s2;
	logic             rej_s2;
	logic             done_s2;
	logic [PIX_W-1:0] pix_s2;
	logic [CW-1:0]    cnt_s2;

	logic             emit;
	logic             pad_item;
	logic             final_copy;
	logic             res_final;
	logic [PIX_W-1:0] res_pix;
	logic             res_is_pad;
	logic [PADB_W-1:0] res_padb;
	logic             res_rend;
	logic             res_last;
	logic             res_rej;

	logic             out_vld_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_is_pad_q;
	logic [PADB_W-1:0] out_padb_q;
	logic             out_rend_q;
	logic             out_last_q;
	logic             out_rej_q;

	assign emit       = v_s2 && (!out_vld_q || m_tready);
	assign pad_item   = done_s2 && (pad_cnt != '0);
	assign final_copy = (cnt_s2 == s_eff - CW'(1));
	assign job_free   = !v_s2 || (emit && res_final);

	always_comb begin
		res_pix    = '0;
		res_is_pad = 1'b0;
		res_padb   = '0;
		res_rend   = 1'b0;
		res_last   = 1'b0;
		res_rej    = 1'b0;
		res_final  = 1'b0;
		if (rej_s2) begin
			res_last  = 1'b1;
			res_rej   = 1'b1;
			res_final = 1'b1;
		end else if (cnt_s2 == s_eff) begin
			// padding item after the last copy of the row
			res_is_pad = 1'b1;
			res_padb   = pad_cnt;
			res_rend   = 1'b1;
			res_last   = 1'b1;
			res_final  = 1'b1;
		end else begin
			res_pix   = pix_s2;
			res_rend  = final_copy && done_s2 && !pad_item;
			res_last  = final_copy && !pad_item;
			res_final = final_copy && !pad_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (job_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_free) begin
			rej_s2  <= rej_s1;
			done_s2 <= done_s1;
			pix_s2  <= use_ram_s1 ? ram_rdata : pix_s1;
			cnt_s2  <= '0;
		end else if (emit) begin
			cnt_s2 <= cnt_s2 + CW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pix_q    <= res_pix;
			out_is_pad_q <= res_is_pad;
			out_padb_q   <= res_padb;
			out_rend_q   <= res_rend;
			out_last_q   <= res_last;
			out_rej_q    <= res_rej;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(M_DATA_W - PIX_W - PADB_W)'(0), out_padb_q, out_pix_q};
	assign m_tuser  = {out_rej_q, out_rend_q, out_is_pad_q};
	assign m_tlast  = out_last_q;

endmodule : pixel_replicate_upscaler_core

`default_nettype wire
